>>> hdl/sdfgb_pkg.sv
// sdfgb_pkg: shared types, codes and saturation helpers for the sdf grid bounce-back block
// no dependencies; imported by sdf_grid_bounceback_top
package sdfgb_pkg;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_LOC  = 6'b000100,
      S_RD   = 6'b001000,
      S_LERP = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      STAT_UNTOUCHED = 2'd0,
      STAT_BOUNCED   = 2'd1,
      STAT_ABANDONED = 2'd2
   } status_type;

   localparam logic MODE_LOAD     = 1'b0;
   localparam logic MODE_PARTICLE = 1'b1;

   localparam logic [2:0] CSR_STEP_TIME  = 3'd0;
   localparam logic [2:0] CSR_BOX_LO_X   = 3'd1;
   localparam logic [2:0] CSR_BOX_LO_Y   = 3'd2;
   localparam logic [2:0] CSR_BOX_LO_Z   = 3'd3;
   localparam logic [2:0] CSR_INV_CELL_X = 3'd4;
   localparam logic [2:0] CSR_INV_CELL_Y = 3'd5;
   localparam logic [2:0] CSR_INV_CELL_Z = 3'd6;

   localparam logic [15:0] STEP_TIME_RST = 16'd655;
   localparam logic [23:0] INV_CELL_RST  = 24'd65536;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -34'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      return sat32(-34'(v));
   endfunction

endpackage

>>> hdl/sdfgb_axis.sv
// sdfgb_axis: one axis of the grid locate, scaled coordinate and periodic cell wrap
// cell wrap by reciprocal multiplication and one compare-subtract; no package dependencies
module sdfgb_axis #(
   parameter int N = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [31:0]       pos,
   input  logic signed [31:0]       lo,
   input  logic [23:0]              inv,
   output logic                     busy,
   output logic [$clog2(N)-1:0]     cell_lo,
   output logic [$clog2(N)-1:0]     cell_hi,
   output logic [15:0]              frac
);

   localparam int IW = $clog2(N);
   localparam int UW = 26;
   localparam int OFS = N * ((2 ** 24 + N - 1) / N);
   localparam logic [25:0] RECIP = 26'((2 ** UW) / N);

   logic signed [32:0] diff;
   logic signed [24:0] scale;
   logic signed [57:0] g_in, g_ff;
   logic [UW-1:0]      u_start, u_ff;
   logic [51:0]        prod_ff;
   logic [25:0]        q_est;
   logic [UW-1:0]      qn;
   logic [IW:0]        r_est_ff;
   logic [IW-1:0]      rem_ff;
   logic [3:0]         pend_ff;

   assign diff    = 33'(pos) - 33'(lo);
   assign scale   = $signed({1'b0, inv});
   assign g_in    = 58'(diff) * 58'(scale);
   assign u_start = UW'(int'($signed(g_ff[56:32])) + OFS);
   assign q_est   = prod_ff[51:26];
   assign qn      = UW'(52'(q_est) * 52'(N));

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= {pend_ff[2:0], start};
      end
   end

   // scale, offset, reciprocal estimate, then one correction
   always_ff @(posedge clock) begin
      if (start) begin
         g_ff <= g_in;
      end
      if (pend_ff[0]) begin
         u_ff <= u_start;
      end
      if (pend_ff[1]) begin
         prod_ff <= 52'(u_ff) * 52'(RECIP);
      end
      if (pend_ff[2]) begin
         r_est_ff <= (IW+1)'(u_ff - qn);
      end
      if (pend_ff[3]) begin
         rem_ff <= (r_est_ff >= (IW+1)'(N)) ? IW'(r_est_ff - (IW+1)'(N)) : IW'(r_est_ff);
      end
   end

   assign busy    = |pend_ff;
   assign frac    = g_ff[31:16];
   assign cell_lo = rem_ff;
   assign cell_hi = (rem_ff == IW'(N - 1)) ? '0 : rem_ff + IW'(1);

`ifndef SYNTH
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff[3] |=> {1'b0, rem_ff} < (IW+1)'(N))
      else $error("cell remainder out of range");
   a_est_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff[3] |-> {1'b0, r_est_ff} < (IW+2)'(2 * N))
      else $error("remainder estimate out of range");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("axis started while busy");
   a_one_pass: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pend_ff))
      else $error("overlapping wrap passes");
`endif

endmodule

>>> hdl/sdf_grid_bounceback_top.sv
// sdf_grid_bounceback_top: periodic signed-distance grid, trilinear sampling, bounce-back
// depends on sdfgb_pkg and sdfgb_axis
//
//  channel | dir | handshake             | payload
//  req     | in  | req_valid / req_stall | mode, grid load or particle fields
//  rsp     | out | rsp_valid / rsp_stall | position, velocity, status, batch_done
//  csr     | in  | csr_we                | csr_index, csr_wdata
//
// a load beat leaves the block idle; an ungrouped particle goes straight to the output state
// one grid sample runs a scale step, the cell wrap, the eight corner reads on the single
// memory port and seven lerp steps
// a grouped particle needs one or two samples
// reset is synchronous; the grid holds no defined data until loaded
// a result waits in the output register while the next beat is accepted
module sdf_grid_bounceback_top #(
   parameter int GRID_X       = 32,
   parameter int GRID_Y       = 32,
   parameter int GRID_Z       = 32,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [14:0]        req_grid_index,
   input  logic signed [15:0] req_grid_value,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic               req_in_group,
   input  logic               req_last_particle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_pos_x,
   output logic signed [31:0] rsp_out_pos_y,
   output logic signed [31:0] rsp_out_pos_z,
   output logic signed [31:0] rsp_out_vel_x,
   output logic signed [31:0] rsp_out_vel_y,
   output logic signed [31:0] rsp_out_vel_z,
   output logic [1:0]         rsp_status,
   output logic               rsp_batch_done
);

   import sdfgb_pkg::*;

   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int AW = $clog2(CELLS);
   localparam int XW = $clog2(GRID_X);
   localparam int YW = $clog2(GRID_Y);
   localparam int ZW = $clog2(GRID_Z);
   localparam int SW = SAMPLE_WIDTH;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       sel_ff, sel_in;
   logic [3:0] rd_cnt_ff, rd_cnt_in;
   logic [2:0] lstep_ff, lstep_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, out_load, start, any_busy, d_pos;

   logic [15:0]        step_time_ff;
   logic signed [31:0] lo_ff [3];
   logic [23:0]        inv_ff [3];

   logic signed [31:0] p_ff [3];
   logic signed [31:0] v_ff [3];
   logic signed [31:0] q_ff [3];
   logic signed [31:0] q_in [3];
   logic signed [31:0] src [3];
   logic               last_ff;

   logic signed [SW-1:0] grid_mem [CELLS];
   logic signed [SW-1:0] mem_q_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa, rd_addr;
   logic signed [SW-1:0] mem_wd;

   logic signed [SW-1:0] buf_ff [8];
   logic signed [SW:0]   ldiff;
   logic signed [SW+17:0] lprod;
   logic [15:0]          lfrac;
   logic signed [SW-1:0] lres;

   logic [XW-1:0] x_lo, x_hi, ax;
   logic [YW-1:0] y_lo, y_hi, ay;
   logic [ZW-1:0] z_lo, z_hi, az;
   logic [15:0]   fx, fy, fz;
   logic          bx, by, bz;

   logic signed [31:0] o_pos [3];
   logic signed [31:0] o_vel [3];

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign start     = (state_ff == S_MUL);
   assign any_busy  = bx | by | bz;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= STEP_TIME_RST;
         lo_ff[0]     <= '0;
         lo_ff[1]     <= '0;
         lo_ff[2]     <= '0;
         inv_ff[0]    <= INV_CELL_RST;
         inv_ff[1]    <= INV_CELL_RST;
         inv_ff[2]    <= INV_CELL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_TIME:  step_time_ff <= csr_wdata[15:0];
            CSR_BOX_LO_X:   lo_ff[0]     <= $signed(csr_wdata);
            CSR_BOX_LO_Y:   lo_ff[1]     <= $signed(csr_wdata);
            CSR_BOX_LO_Z:   lo_ff[2]     <= $signed(csr_wdata);
            CSR_INV_CELL_X: inv_ff[0]    <= csr_wdata[23:0];
            CSR_INV_CELL_Y: inv_ff[1]    <= csr_wdata[23:0];
            CSR_INV_CELL_Z: inv_ff[2]    <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // back step and source select per lane
   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic signed [48:0] dv;
      logic signed [33:0] back;
      assign dv      = 49'($signed({1'b0, step_time_ff})) * 49'(v_ff[i]);
      assign back    = 34'(p_ff[i]) - 34'(dv >>> 16);
      assign q_in[i] = sat32(back);
      assign src[i]  = sel_ff ? q_ff[i] : p_ff[i];
      assign o_pos[i] = (status_ff == STAT_BOUNCED) ? q_ff[i] : p_ff[i];
      assign o_vel[i] = (status_ff == STAT_BOUNCED) ? neg_sat(v_ff[i]) : v_ff[i];
   end

   sdfgb_axis #(.N(GRID_X)) u_axis_x (
      .clock(clock), .reset(reset), .start(start), .pos(src[0]), .lo(lo_ff[0]),
      .inv(inv_ff[0]), .busy(bx), .cell_lo(x_lo), .cell_hi(x_hi), .frac(fx)
   );
   sdfgb_axis #(.N(GRID_Y)) u_axis_y (
      .clock(clock), .reset(reset), .start(start), .pos(src[1]), .lo(lo_ff[1]),
      .inv(inv_ff[1]), .busy(by), .cell_lo(y_lo), .cell_hi(y_hi), .frac(fy)
   );
   sdfgb_axis #(.N(GRID_Z)) u_axis_z (
      .clock(clock), .reset(reset), .start(start), .pos(src[2]), .lo(lo_ff[2]),
      .inv(inv_ff[2]), .busy(bz), .cell_lo(z_lo), .cell_hi(z_hi), .frac(fz)
   );

   // grid memory
   assign mem_we = accept && (req_mode == MODE_LOAD) && (int'(req_grid_index) < CELLS);
   assign mem_wa = AW'(req_grid_index);
   assign mem_wd = SW'(req_grid_value);

   assign ax = rd_cnt_ff[0] ? x_hi : x_lo;
   assign ay = rd_cnt_ff[1] ? y_hi : y_lo;
   assign az = rd_cnt_ff[2] ? z_hi : z_lo;
   assign rd_addr = AW'(int'(ax) + GRID_X * (int'(ay) + GRID_Y * int'(az)));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= grid_mem[rd_addr];
   end

   // one lerp step on the two head entries
   always_comb begin
      if (lstep_ff < 3'd4) begin
         lfrac = fx;
      end else if (lstep_ff < 3'd6) begin
         lfrac = fy;
      end else begin
         lfrac = fz;
      end
   end

   assign ldiff = (SW+1)'(buf_ff[1]) - (SW+1)'(buf_ff[0]);
   assign lprod = (SW+18)'(ldiff) * (SW+18)'($signed({1'b0, lfrac}));
   assign lres  = SW'((SW+2)'(buf_ff[0]) + (SW+2)'(lprod >>> 16));
   assign d_pos = !lres[SW-1] && (lres != '0);

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      sel_in    = sel_ff;
      rd_cnt_in = rd_cnt_ff;
      lstep_in  = lstep_ff;
      out_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_mode == MODE_PARTICLE) begin
               sel_in    = 1'b0;
               status_in = STAT_UNTOUCHED;
               state_in  = req_in_group ? S_MUL : S_OUT;
            end
         end
         S_MUL: begin
            state_in = S_LOC;
         end
         S_LOC: begin
            if (!any_busy) begin
               rd_cnt_in = '0;
               state_in  = S_RD;
            end
         end
         S_RD: begin
            rd_cnt_in = rd_cnt_ff + 4'd1;
            if (rd_cnt_ff == 4'd8) begin
               rd_cnt_in = '0;
               lstep_in  = '0;
               state_in  = S_LERP;
            end
         end
         S_LERP: begin
            lstep_in = lstep_ff + 3'd1;
            if (lstep_ff == 3'd6) begin
               if (!sel_ff) begin
                  if (d_pos) begin
                     sel_in   = 1'b1;
                     state_in = S_MUL;
                  end else begin
                     status_in = STAT_UNTOUCHED;
                     state_in  = S_OUT;
                  end
               end else begin
                  status_in = d_pos ? STAT_ABANDONED : STAT_BOUNCED;
                  state_in  = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= STAT_UNTOUCHED;
         sel_ff       <= 1'b0;
         rd_cnt_ff    <= '0;
         lstep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         sel_ff       <= sel_in;
         rd_cnt_ff    <= rd_cnt_in;
         lstep_ff     <= lstep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // particle and working data
   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_PARTICLE) begin
         p_ff[0] <= req_pos_x;
         p_ff[1] <= req_pos_y;
         p_ff[2] <= req_pos_z;
         v_ff[0] <= req_vel_x;
         v_ff[1] <= req_vel_y;
         v_ff[2] <= req_vel_z;
         last_ff <= req_last_particle;
      end
      if (state_ff == S_MUL && !sel_ff) begin
         q_ff[0] <= q_in[0];
         q_ff[1] <= q_in[1];
         q_ff[2] <= q_in[2];
      end
      if (state_ff == S_RD && rd_cnt_ff != 4'd0) begin
         buf_ff[3'(rd_cnt_ff - 4'd1)] <= mem_q_ff;
      end
      if (state_ff == S_LERP) begin
         for (int i = 0; i < 8; i++) begin
            if (i == 6 - int'(lstep_ff)) begin
               buf_ff[i] <= lres;
            end else if (i < 6) begin
               buf_ff[i] <= buf_ff[(i + 2) % 8];
            end
         end
      end
      if (out_load) begin
         rsp_out_pos_x  <= o_pos[0];
         rsp_out_pos_y  <= o_pos[1];
         rsp_out_pos_z  <= o_pos[2];
         rsp_out_vel_x  <= o_vel[0];
         rsp_out_vel_y  <= o_vel[1];
         rsp_out_vel_z  <= o_vel[2];
         rsp_status     <= status_ff;
         rsp_batch_done <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_second_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LERP && lstep_ff == 3'd6 && sel_ff |=> state_ff == S_OUT)
      else $error("second sample did not finish the particle");
   a_bounce_sel: assert property (@(posedge clock) disable iff (reset)
      out_load && status_ff == STAT_BOUNCED |-> sel_ff)
      else $error("bounce without a back-step sample");
   a_rd_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> rd_cnt_ff <= 4'd8)
      else $error("corner read count overrun");
   a_lerp_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_LERP) |-> lstep_ff == 3'd0)
      else $error("lerp sequence entered mid-way");
`endif

endmodule
